### hw/rtl/nfpa_pkg.sv
// Shared types and constants of the next-fit page allocator.
// Request and response words, status codes and the row find-first helper.
// No dependencies.
package nfpa_pkg;

   localparam int ROW_BITS = 32;
   localparam int BIT_W    = 5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_DOUBLE = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic       cmd;
      logic [9:0] page_index;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] page_index_res;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } ffs_type;

   // Lowest set bit of one map row.
   function automatic ffs_type first_set(input logic [ROW_BITS-1:0] v);
      ffs_type res;
      res = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            res.found = 1'b1;
            res.pos   = BIT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

### hw/rtl/next_fit_page_allocator.sv
// Next-fit page allocator: top level, free map memory and its sequencer.
// Depends on nfpa_pkg.
//
// One free bit per page, kept in a synchronous memory of 32-bit rows
// (ceil(POOL_PAGES/32) rows, registered read). A word is taken when
// start is high and busy is low; its response appears on rsp_data for one
// cycle with rsp_valid and cannot be held off. A free reads the row, then
// checks the bit and writes the row back; an out-of-range free answers
// straight from idle. An allocate that hits the last-freed hint is granted
// from that row's read; otherwise the row reads stream one per cycle through
// a 32-bit find-first stage, so a scan's length is set by the number
// of rows the next-fit walk has to visit (it wraps around to the start
// row's lower part last). Busy stays high after reset while a clearing
// pass marks every page free; padding bits of the last row are written
// as taken so a scan never grants them. Only one word is in flight, and
// the row write-back lands at the edge that returns the sequencer to
// idle, so the next read always sees it.
module next_fit_page_allocator
   import nfpa_pkg::*;
#(
   parameter int POOL_PAGES = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int ROWS   = (POOL_PAGES + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = $clog2(POOL_PAGES);
   localparam int EXT_W  = ROW_AW + BIT_W;
   localparam int CNT_W  = $clog2(ROWS + 1);
   localparam logic [ROW_AW-1:0]   LAST_ROW  = ROW_AW'(ROWS - 1);
   localparam logic [ROW_BITS-1:0] LAST_MASK = (POOL_PAGES % ROW_BITS == 0) ?
      {ROW_BITS{1'b1}} : ((ROW_BITS'(1) << (POOL_PAGES % ROW_BITS)) - ROW_BITS'(1));

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HINT  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FREE  = 5'b10000
   } state_type;

   function automatic logic [ROW_AW-1:0] row_of(input logic [IDX_W-1:0] page);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(page);
      return ext[EXT_W-1:BIT_W];
   endfunction

   function automatic logic [BIT_W-1:0] bit_of(input logic [IDX_W-1:0] page);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(page);
      return ext[BIT_W-1:0];
   endfunction

   // Free map storage.
   logic [ROW_BITS-1:0] free_mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_en;
   logic [ROW_AW-1:0]   rd_addr;
   logic                wr_en;
   logic [ROW_AW-1:0]   wr_addr;
   logic [ROW_BITS-1:0] wr_data;

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [ROW_AW-1:0] clr_row_ff, clr_row_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [BIT_W-1:0]  sbit_ff, sbit_in;
   logic [ROW_AW-1:0] rd_row_ff, rd_row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Hints.
   logic [IDX_W-1:0] alloc_idx_ff, alloc_idx_in;
   logic             alloc_valid_ff, alloc_valid_in;
   logic [IDX_W-1:0] freed_idx_ff, freed_idx_in;
   logic             freed_valid_ff, freed_valid_in;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Grant path shared by the hint hit and the scan hit.
   logic              grant_en;
   logic [ROW_AW-1:0] grant_row;
   logic [BIT_W-1:0]  grant_bit;
   logic [IDX_W-1:0]  start_page;
   logic [ROW_BITS-1:0] scan_mask;
   ffs_type           scan_hit;
   logic              req_in_range;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= free_mem[rd_addr];
      end
   end

   assign start_page   = alloc_valid_ff ? alloc_idx_ff : '0;
   assign req_in_range = 32'(req_data.page_index) < POOL_PAGES;

   // First row keeps bits at or above the start bit, the wrapped visit of
   // the same row keeps the bits below it.
   always_comb begin
      if (cnt_ff == '0) begin
         scan_mask = {ROW_BITS{1'b1}} << sbit_ff;
      end else if (cnt_ff == CNT_W'(ROWS)) begin
         scan_mask = ~({ROW_BITS{1'b1}} << sbit_ff);
      end else begin
         scan_mask = {ROW_BITS{1'b1}};
      end
   end

   assign scan_hit = first_set(rd_data_ff & scan_mask);

   always_comb begin
      state_in       = state_ff;
      clr_row_in     = clr_row_ff;
      free_idx_in    = free_idx_ff;
      sbit_in        = sbit_ff;
      rd_row_in      = rd_row_ff;
      cnt_in         = cnt_ff;
      alloc_idx_in   = alloc_idx_ff;
      alloc_valid_in = alloc_valid_ff;
      freed_idx_in   = freed_idx_ff;
      freed_valid_in = freed_valid_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      grant_en       = 1'b0;
      grant_row      = '0;
      grant_bit      = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_row_ff;
            wr_data = (clr_row_ff == LAST_ROW) ? LAST_MASK : {ROW_BITS{1'b1}};
            if (clr_row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end else begin
               clr_row_in = clr_row_ff + ROW_AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.cmd == CMD_FREE) begin
                  if (!req_in_range) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STATUS_RANGE, page_index_res: '0};
                  end else begin
                     free_idx_in = IDX_W'(req_data.page_index);
                     rd_en       = 1'b1;
                     rd_addr     = row_of(IDX_W'(req_data.page_index));
                     state_in    = ST_FREE;
                  end
               end else if (freed_valid_ff) begin
                  // Try the last-freed page first; the hint is spent either way.
                  freed_valid_in = 1'b0;
                  rd_en          = 1'b1;
                  rd_addr        = row_of(freed_idx_ff);
                  state_in       = ST_HINT;
               end else begin
                  alloc_valid_in = 1'b0;
                  sbit_in        = bit_of(start_page);
                  rd_en          = 1'b1;
                  rd_addr        = row_of(start_page);
                  rd_row_in      = row_of(start_page);
                  cnt_in         = '0;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_HINT: begin
            if (rd_data_ff[bit_of(freed_idx_ff)]) begin
               grant_en  = 1'b1;
               grant_row = row_of(freed_idx_ff);
               grant_bit = bit_of(freed_idx_ff);
            end else begin
               alloc_valid_in = 1'b0;
               sbit_in        = bit_of(start_page);
               rd_en          = 1'b1;
               rd_addr        = row_of(start_page);
               rd_row_in      = row_of(start_page);
               cnt_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit.found) begin
               grant_en  = 1'b1;
               grant_row = rd_row_ff;
               grant_bit = scan_hit.pos;
            end else if (cnt_ff == CNT_W'(ROWS)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_EMPTY, page_index_res: '0};
               state_in     = ST_IDLE;
            end else begin
               // Advance to the next row, wrapping at the end of the map.
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_en   = 1'b1;
               rd_addr = (rd_row_ff == LAST_ROW) ? '0 : rd_row_ff + ROW_AW'(1);
               rd_row_in = rd_addr;
            end
         end
         ST_FREE: begin
            if (rd_data_ff[bit_of(free_idx_ff)]) begin
               rsp_in = '{status: STATUS_DOUBLE, page_index_res: '0};
            end else begin
               wr_en          = 1'b1;
               wr_addr        = row_of(free_idx_ff);
               wr_data        = rd_data_ff | (ROW_BITS'(1) << bit_of(free_idx_ff));
               freed_idx_in   = free_idx_ff;
               freed_valid_in = 1'b1;
               rsp_in         = '{status: STATUS_OK, page_index_res: '0};
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take the page: clear its bit, record it as last allocated, answer.
      if (grant_en) begin
         wr_en          = 1'b1;
         wr_addr        = grant_row;
         wr_data        = rd_data_ff & ~(ROW_BITS'(1) << grant_bit);
         alloc_idx_in   = IDX_W'({grant_row, grant_bit});
         alloc_valid_in = 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_in         = '{status: STATUS_OK,
                            page_index_res: 7'(IDX_W'({grant_row, grant_bit}))};
         state_in       = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         alloc_idx_ff   <= '0;
         alloc_valid_ff <= 1'b0;
         freed_idx_ff   <= '0;
         freed_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         alloc_idx_ff   <= alloc_idx_in;
         alloc_valid_ff <= alloc_valid_in;
         freed_idx_ff   <= freed_idx_in;
         freed_valid_ff <= freed_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      sbit_ff     <= sbit_in;
      rd_row_ff   <= rd_row_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/nfpa_checker.sv
// Port-level checks of the next-fit page allocator, bound to its top level.
// Depends on nfpa_pkg and next_fit_page_allocator.
module nfpa_checker
   import nfpa_pkg::*;
#(
   parameter int POOL_PAGES = 128
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted word either answers at once or holds the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted word neither answered nor kept busy");

   // A response always comes with the sequencer back at idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // Failed requests carry no page.
   a_err_no_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.page_index_res == '0)
      else $error("error response with nonzero page");

   // A free beyond the pool is refused in the next cycle.
   a_range: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == CMD_FREE &&
      32'(req_data.page_index) >= POOL_PAGES
      |=> rsp_valid && rsp_data.status == STATUS_RANGE)
      else $error("out-of-range free not refused");

endmodule

bind next_fit_page_allocator nfpa_checker #(.POOL_PAGES(POOL_PAGES)) u_nfpa_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

### verif/next_fit_page_allocator_tb.sv
// Self-checking testbench for next_fit_page_allocator: directed and random words
// checked against a cycle-free model of the page pool and its two hints.
// Depends on nfpa_pkg and the next_fit_page_allocator RTL.
`timescale 1ns / 100ps

module next_fit_page_allocator_tb;
   import nfpa_pkg::*;

   localparam int POOL_PAGES  = 128;
   localparam int NUM_WORDS   = 1850;
   // Drop sender idling for this many trailing words.
   localparam int QUIET_TAIL  = 150;
   // Drain time after the last response; give the tail plenty of margin.
   localparam int DRAIN_CYCLES = 20;

   // Page pool as the allocator sees it: free bits plus both hints.
   typedef struct {
      logic [POOL_PAGES-1:0] free_map;
      logic [6:0]            alloc_hint;
      logic                  alloc_hint_ok;
      logic [6:0]            freed_hint;
      logic                  freed_hint_ok;
   } pool_state_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type        pending_words[$];
   rsp_type        expected_rsp[$];
   pool_state_type pool_model;
   pool_state_type plan_pool;

   int gap_left;
   int words_sent;
   int rsp_seen;
   int err_count;
   int alloc_count;
   int free_count;
   int status_hits[4];

   next_fit_page_allocator #(
      .POOL_PAGES(POOL_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Empty pool state: every page free, both hints empty.
   function automatic pool_state_type fresh_pool();
      pool_state_type s;
      s.free_map      = '1;
      s.alloc_hint    = '0;
      s.alloc_hint_ok = 1'b0;
      s.freed_hint    = '0;
      s.freed_hint_ok = 1'b0;
      return s;
   endfunction

   // Apply one word to a pool state and return the response it earns.
   function automatic rsp_type serve_word(inout pool_state_type s, input req_type r);
      rsp_type res;
      int      first_pg;
      int      pg;
      logic    granted;
      res     = '{status: STATUS_OK, page_index_res: 7'd0};
      granted = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
         // Try the last-freed hint first; consume it whether it hits or not.
         if (s.freed_hint_ok) begin
            s.freed_hint_ok = 1'b0;
            if (s.free_map[s.freed_hint]) begin
               granted            = 1'b1;
               res.page_index_res = s.freed_hint;
            end
         end
         // Fall back to a circular next-fit walk from the last grant.
         if (!granted) begin
            first_pg        = s.alloc_hint_ok ? int'(s.alloc_hint) : 0;
            s.alloc_hint_ok = 1'b0;
            for (int n = 0; n < POOL_PAGES; n++) begin
               pg = (first_pg + n) % POOL_PAGES;
               if (!granted && s.free_map[pg]) begin
                  granted            = 1'b1;
                  res.page_index_res = 7'(pg);
               end
            end
         end
         if (granted) begin
            s.free_map[res.page_index_res] = 1'b0;
            s.alloc_hint                   = res.page_index_res;
            s.alloc_hint_ok                = 1'b1;
         end else begin
            res.status = STATUS_EMPTY;
         end
      end else if (r.page_index >= POOL_PAGES) begin
         res.status = STATUS_RANGE;
      end else if (s.free_map[r.page_index]) begin
         res.status = STATUS_DOUBLE;
      end else begin
         s.free_map[r.page_index] = 1'b1;
         s.freed_hint             = r.page_index[6:0];
         s.freed_hint_ok          = 1'b1;
      end
      return res;
   endfunction

   // Queue one word and advance the planning copy of the pool.
   task automatic queue_word(input logic cmd, input logic [9:0] idx);
      req_type r;
      r.cmd        = cmd;
      r.page_index = idx;
      pending_words.push_back(r);
      void'(serve_word(plan_pool, r));
   endtask

   // Find a page with the wanted free bit, starting at a random offset.
   // Return -1 if no page matches.
   function automatic int pick_page(input logic want_free);
      int off;
      int pg;
      int hit;
      off = $urandom_range(0, POOL_PAGES - 1);
      hit = -1;
      for (int n = 0; n < POOL_PAGES; n++) begin
         pg = (off + n) % POOL_PAGES;
         if (hit < 0 && plan_pool.free_map[pg] == want_free) hit = pg;
      end
      return hit;
   endfunction

   // One random word: mostly allocs or frees of granted pages per the bias,
   // with some out-of-range and double frees mixed in as noise.
   task automatic queue_random_word(input int alloc_pct);
      int roll;
      int pg;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
         queue_word(CMD_ALLOC, 10'($urandom));
      end else begin
         roll = $urandom_range(0, 99);
         pg   = pick_page(1'b0);
         if (roll < 80 && pg >= 0) begin
            queue_word(CMD_FREE, 10'(pg));
         end else if (roll < 90) begin
            queue_word(CMD_FREE, 10'($urandom_range(POOL_PAGES, 1023)));
         end else begin
            pg = pick_page(1'b1);
            queue_word(CMD_FREE, pg >= 0 ? 10'(pg) : 10'($urandom_range(0, POOL_PAGES - 1)));
         end
      end
   endtask

   task automatic build_stimulus();
      int seg_len;
      int bias;
      plan_pool = fresh_pool();
      // Directed: first grants from an empty pool, range and double-free
      // errors, freed-hint hits and the hint being overwritten.
      queue_word(CMD_ALLOC, 10'd1023);   // grant 0, scan from page 0
      queue_word(CMD_ALLOC, 10'd0);      // grant 1, skip the hinted page
      queue_word(CMD_FREE, 10'd128);     // just past the pool
      queue_word(CMD_FREE, 10'd1023);    // largest index
      queue_word(CMD_FREE, 10'd127);     // top page, still free
      queue_word(CMD_FREE, 10'd0);       // ok, freed hint = 0
      queue_word(CMD_ALLOC, 10'h2AA);    // freed hint hit
      queue_word(CMD_FREE, 10'd1);
      queue_word(CMD_FREE, 10'd0);       // overwrite the freed hint
      queue_word(CMD_ALLOC, 10'h155);    // grant 0 from the hint
      queue_word(CMD_ALLOC, 10'd0);      // walk from 0, grant 1
      queue_word(CMD_ALLOC, 10'd0);      // grant 2
      queue_word(CMD_FREE, 10'd0);
      queue_word(CMD_FREE, 10'd0);       // double free keeps the hint
      queue_word(CMD_ALLOC, 10'd0);      // hint still hits page 0
      queue_word(CMD_FREE, 10'd2);
      queue_word(CMD_FREE, 10'd1);
      queue_word(CMD_ALLOC, 10'd0);      // hint page 1
      queue_word(CMD_ALLOC, 10'd0);      // walk from 1, grant 2
      // Fill hard first so the pool runs dry and the empty status shows up.
      for (int i = 0; i < 170; i++) queue_random_word(95);
      // Then alternate fill, churn and drain segments.
      while (pending_words.size() < NUM_WORDS) begin
         seg_len = $urandom_range(30, 150);
         case ($urandom_range(0, 2))
            0: bias = 85;
            1: bias = 50;
            default: bias = 20;
         endcase
         for (int i = 0; i < seg_len && pending_words.size() < NUM_WORDS; i++)
            queue_random_word(bias);
      end
   endtask

   // Driver: present queued words on start, hold them while busy, and
   // insert random idle bursts until the quiet tail.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (start && !busy) begin
            // Word taken at this edge: predict its response now.
            exp_rsp = serve_word(pool_model, req_data);
            expected_rsp.push_back(exp_rsp);
            status_hits[exp_rsp.status]++;
            if (req_data.cmd == CMD_ALLOC) alloc_count++;
            else free_count++;
            words_sent++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               start    <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_words.size() > QUIET_TAIL &&
                         $urandom_range(0, 3) == 0) begin
               start    <= 1'b0;
               gap_left <= $urandom_range(1, 5) - 1;
            end else if (pending_words.size() > 0) begin
               start    <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed response must match the oldest prediction.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("response with nothing outstanding: status %0d page %0d",
                   rsp_data.status, rsp_data.page_index_res);
            err_count++;
         end else begin
            exp_rsp = expected_rsp.pop_front();
            rsp_seen++;
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status mismatch: expected %0d actual %0d",
                      exp_rsp.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.page_index_res !== exp_rsp.page_index_res) begin
               $error("page_index_res mismatch: expected %0d actual %0d",
                      exp_rsp.page_index_res, rsp_data.page_index_res);
               err_count++;
            end
         end
      end
   end

   initial begin
      gap_left    = 0;
      words_sent  = 0;
      rsp_seen    = 0;
      err_count   = 0;
      alloc_count = 0;
      free_count  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      pool_model  = fresh_pool();
      build_stimulus();

      // Hold reset, then release it once.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Advance until every word is taken and every response has come back.
      while (pending_words.size() != 0 || start || expected_rsp.size() != 0)
         @(posedge clock);
      // Let stray responses surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp.size());
         err_count++;
      end

      $display("Covered %0d words (%0d allocs, %0d frees), %0d responses checked",
               words_sent, alloc_count, free_count, rsp_seen);
      $display("Statuses seen: ok %0d, out of range %0d, double free %0d, pool empty %0d",
               status_hits[STATUS_OK], status_hits[STATUS_RANGE],
               status_hits[STATUS_DOUBLE], status_hits[STATUS_EMPTY]);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(4_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
